// ----- sv/sorted_interval_set_table_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted interval set table: assertion macros
// Shared macros for the concurrent checks of the interval set table.
// ----------------------------------------------------------------------------
`ifndef SORTED_INTERVAL_SET_TABLE_DEFINES_SVH
`define SORTED_INTERVAL_SET_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sist_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted interval set table package
// Widths, operation codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none
package sist_pkg;

   localparam int VAL_W           = 63;
   localparam int OP_W            = 2;
   localparam int SRC_W           = 4;
   localparam int CNT_OUT_W       = 5;
   localparam int NUM_SOURCES_DEF = 16;
   localparam int MAX_RANGES_DEF  = 16;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_COUNT  = 2'd2;
   // The spare code behaves as a count query.
   localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic cnt_rd;
      logic init1;
      logic rd1;
      logic pr1;
      logic end1;
      logic init2;
      logic rd2;
      logic pr2;
      logic ex2;
      logic end2;
      logic fin;
      logic cap_old;
      logic cap_zero;
   } sist_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_end;
      logic two_emit;
      logic src_bad;
      logic full;
      logic pass;
   } sist_sts_type;

endpackage
`default_nettype wire

// ----- sv/sist_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted interval set table controller
// Sequences the count read, the scan pass and the rewrite pass.
// ----------------------------------------------------------------------------
`default_nettype none
module sist_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sist_pkg::sist_cmd_type cmd,
   input  sist_pkg::sist_sts_type sts
);
   import sist_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CNT  = 4'd1;
   localparam logic [3:0] S_INI1 = 4'd2;
   localparam logic [3:0] S_RD1  = 4'd3;
   localparam logic [3:0] S_PR1  = 4'd4;
   localparam logic [3:0] S_END1 = 4'd5;
   localparam logic [3:0] S_DEC  = 4'd6;
   localparam logic [3:0] S_RD2  = 4'd7;
   localparam logic [3:0] S_PR2  = 4'd8;
   localparam logic [3:0] S_EX2  = 4'd9;
   localparam logic [3:0] S_END2 = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;
   localparam logic [3:0] S_RESP = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_CNT;
         end
         S_CNT: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_INI1;
         end
         S_INI1: begin
            cmd.init1 = 1'b1;
            state_in  = S_RD1;
         end
         S_RD1: begin
            cmd.rd1  = !sts.at_end;
            state_in = sts.at_end ? S_END1 : S_PR1;
         end
         S_PR1: begin
            cmd.pr1  = 1'b1;
            state_in = S_RD1;
         end
         S_END1: begin
            cmd.end1 = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            priority if (sts.src_bad) begin
               cmd.cap_zero = 1'b1;
               state_in     = S_RESP;
            end else if (sts.pass || sts.full) begin
               cmd.cap_old = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.init2 = 1'b1;
               state_in  = S_RD2;
            end
         end
         S_RD2: begin
            cmd.rd2  = !sts.at_end;
            state_in = sts.at_end ? S_END2 : S_PR2;
         end
         S_PR2: begin
            cmd.pr2  = 1'b1;
            state_in = sts.two_emit ? S_EX2 : S_RD2;
         end
         S_EX2: begin
            cmd.ex2  = 1'b1;
            state_in = S_RD2;
         end
         S_END2: begin
            cmd.end2 = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/sist_dp.sv -----
// ----------------------------------------------------------------------------
// Sorted interval set table datapath
// Range memories, scratch copy, merge/trim unit, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sist_dp #(
   parameter int NUM_SOURCES = sist_pkg::NUM_SOURCES_DEF,
   parameter int MAX_RANGES  = sist_pkg::MAX_RANGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sist_pkg::OP_W-1:0]     req_operation,
   input  logic [sist_pkg::SRC_W-1:0]    req_source,
   input  logic [sist_pkg::VAL_W-1:0]    req_range_begin,
   input  logic [sist_pkg::VAL_W-1:0]    req_range_end,
   input  sist_pkg::sist_cmd_type        cmd,
   output sist_pkg::sist_sts_type        sts,
   output logic                          rsp_status,
   output logic [sist_pkg::VAL_W-1:0]    rsp_number_count,
   output logic [sist_pkg::CNT_OUT_W-1:0] rsp_range_count
);
   import sist_pkg::*;

   localparam int DEPTH = NUM_SOURCES * MAX_RANGES;
   localparam int CW    = $clog2(MAX_RANGES + 1);
   localparam int OW    = $clog2(MAX_RANGES + 2);
   localparam int IW    = $clog2(MAX_RANGES);
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   logic [VAL_W-1:0] main_s_mem [DEPTH];
   logic [VAL_W-1:0] main_l_mem [DEPTH];
   logic [VAL_W-1:0] scr_s_mem  [MAX_RANGES];
   logic [VAL_W-1:0] scr_l_mem  [MAX_RANGES];
   logic [CW-1:0]    cnt_mem    [NUM_SOURCES];

   logic [NUM_SOURCES-1:0] vld_ff;
   logic [OP_W-1:0]  op_ff;
   logic [SRC_W-1:0] src_ff;
   logic [VAL_W-1:0] b_ff, e_ff;
   logic [CW-1:0]    cnt_q_ff, n_ff, r_ff, w_ff;
   logic [OW-1:0]    oc_ff;
   logic [VAL_W-1:0] tot_old_ff, tot_new_ff;
   logic [VAL_W-1:0] nb_ff, ne_ff;
   logic             placed_ff;
   logic [VAL_W-1:0] mrd_s_ff, mrd_l_ff, srd_s_ff, srd_l_ff;
   logic [VAL_W-1:0] hold_s_ff, hold_l_ff;

   logic [SW-1:0]    src_ix;
   logic [AW-1:0]    base, rd_addr, wr_addr;
   logic [VAL_W-1:0] cur_s, cur_l;
   logic             e0_v, e1_v, fin_v;
   logic [VAL_W-1:0] e0_s, e0_l, e1_s, e1_l;
   logic [VAL_W-1:0] nb_in, ne_in;
   logic             placed_in;
   logic             pass_w, src_bad_w;

   assign src_ix    = SW'(src_ff);
   assign base      = AW'(src_ff) * AW'(MAX_RANGES);
   assign rd_addr   = base + AW'(r_ff);
   assign wr_addr   = base + AW'(w_ff);
   assign pass_w    = !(((op_ff == OP_ADD) || (op_ff == OP_REMOVE)) && (e_ff > b_ff));
   assign src_bad_w = (int'(src_ff) >= NUM_SOURCES);
   assign cur_s     = cmd.pr2 ? srd_s_ff : mrd_s_ff;
   assign cur_l     = cmd.pr2 ? srd_l_ff : mrd_l_ff;
   assign fin_v     = (op_ff == OP_ADD) && !placed_ff;

   // Streaming merge (add) or trim/split (remove) of one stored range.
   always_comb begin
      e0_v      = 1'b0;
      e1_v      = 1'b0;
      e0_s      = cur_s;
      e0_l      = cur_l;
      e1_s      = cur_s;
      e1_l      = cur_l;
      nb_in     = nb_ff;
      ne_in     = ne_ff;
      placed_in = placed_ff;
      if (op_ff == OP_ADD) begin
         priority if (placed_ff || (cur_l < nb_ff)) begin
            e0_v = 1'b1;
         end else if (cur_s > ne_ff) begin
            e0_v      = 1'b1;
            e0_s      = nb_ff;
            e0_l      = ne_ff;
            e1_v      = 1'b1;
            placed_in = 1'b1;
         end else begin
            nb_in = (cur_s < nb_ff) ? cur_s : nb_ff;
            ne_in = (cur_l > ne_ff) ? cur_l : ne_ff;
         end
      end else begin
         e0_v = (cur_s < b_ff) || (cur_l > e_ff);
         e1_v = (cur_s < b_ff) && (cur_l > e_ff);
         e1_s = (cur_s > e_ff) ? cur_s : e_ff;
         if (cur_s < b_ff) begin
            e0_l = (cur_l < b_ff) ? cur_l : b_ff;
         end else begin
            e0_s = e1_s;
         end
      end
   end

   assign sts.at_end   = (r_ff == n_ff);
   assign sts.two_emit = e1_v;
   assign sts.src_bad  = src_bad_w;
   assign sts.full     = (int'(oc_ff) > MAX_RANGES);
   assign sts.pass     = pass_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.fin) begin
         vld_ff[src_ix] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         src_ff <= req_source;
         b_ff   <= req_range_begin;
         e_ff   <= req_range_end;
      end
      if (cmd.cnt_rd) begin
         cnt_q_ff <= cnt_mem[src_ix];
      end
      if (cmd.init1) begin
         n_ff       <= (src_bad_w || !vld_ff[src_ix]) ? '0 : cnt_q_ff;
         r_ff       <= '0;
         oc_ff      <= '0;
         tot_old_ff <= '0;
         nb_ff      <= b_ff;
         ne_ff      <= e_ff;
         placed_ff  <= 1'b0;
      end
      if (cmd.rd1) begin
         mrd_s_ff <= main_s_mem[rd_addr];
         mrd_l_ff <= main_l_mem[rd_addr];
      end
      if (cmd.pr1) begin
         scr_s_mem[r_ff[IW-1:0]] <= cur_s;
         scr_l_mem[r_ff[IW-1:0]] <= cur_l;
         oc_ff      <= oc_ff + OW'(e0_v) + OW'(e1_v);
         tot_old_ff <= tot_old_ff + (cur_l - cur_s);
         r_ff       <= r_ff + CW'(1);
         nb_ff      <= nb_in;
         ne_ff      <= ne_in;
         placed_ff  <= placed_in;
      end
      if (cmd.end1) begin
         oc_ff <= oc_ff + OW'(fin_v);
      end
      if (cmd.init2) begin
         r_ff       <= '0;
         w_ff       <= '0;
         tot_new_ff <= '0;
         nb_ff      <= b_ff;
         ne_ff      <= e_ff;
         placed_ff  <= 1'b0;
      end
      if (cmd.rd2) begin
         srd_s_ff <= scr_s_mem[r_ff[IW-1:0]];
         srd_l_ff <= scr_l_mem[r_ff[IW-1:0]];
      end
      if (cmd.pr2) begin
         if (e0_v) begin
            main_s_mem[wr_addr] <= e0_s;
            main_l_mem[wr_addr] <= e0_l;
            tot_new_ff          <= tot_new_ff + (e0_l - e0_s);
            w_ff                <= w_ff + CW'(1);
         end
         hold_s_ff <= e1_s;
         hold_l_ff <= e1_l;
         r_ff      <= r_ff + CW'(1);
         nb_ff     <= nb_in;
         ne_ff     <= ne_in;
         placed_ff <= placed_in;
      end
      if (cmd.ex2) begin
         main_s_mem[wr_addr] <= hold_s_ff;
         main_l_mem[wr_addr] <= hold_l_ff;
         tot_new_ff          <= tot_new_ff + (hold_l_ff - hold_s_ff);
         w_ff                <= w_ff + CW'(1);
      end
      if (cmd.end2 && fin_v) begin
         main_s_mem[wr_addr] <= nb_ff;
         main_l_mem[wr_addr] <= ne_ff;
         tot_new_ff          <= tot_new_ff + (ne_ff - nb_ff);
         w_ff                <= w_ff + CW'(1);
      end
      if (cmd.fin) begin
         cnt_mem[src_ix]  <= w_ff;
         rsp_status       <= 1'b0;
         rsp_number_count <= tot_new_ff;
         rsp_range_count  <= CNT_OUT_W'(w_ff);
      end
      if (cmd.cap_old) begin
         rsp_status       <= !pass_w;
         rsp_number_count <= tot_old_ff;
         rsp_range_count  <= CNT_OUT_W'(n_ff);
      end
      if (cmd.cap_zero) begin
         rsp_status       <= 1'b0;
         rsp_number_count <= '0;
         rsp_range_count  <= '0;
      end
   end

endmodule
`default_nettype wire

// ----- sv/sorted_interval_set_table.sv -----
// ----------------------------------------------------------------------------
// Sorted interval set table
// Per-source sorted lists of disjoint half-open ranges with add, remove and
// count operations.
// ----------------------------------------------------------------------------
// Usage: a request transfer on the req_ channel carries an operation (add,
// remove or count), a source and a half-open range. Exactly one response
// transfer follows on the rsp_ channel with a full flag, the total count of
// covered numbers and the number of stored ranges of that source after the
// operation. The block works on one request at a time: req_stall stays high
// from the accepting edge until the response transfer completes, and the
// next request can be taken in the cycle after that transfer.
// Timing depends on the n ranges stored for the source: a count query, an
// empty range, a full table or an unknown source answers after the scan pass
// alone; an add or remove that rewrites the list also runs the rewrite pass,
// with an extra step when a range is inserted ahead of a stored range or a
// range is split. The scan pass copies the list into a scratch buffer and
// counts the result, then the rewrite pass streams it back through the
// merge/trim unit, each entry passing a read state and a process state. Reset
// empties every source's list at once; no clearing pass runs. While rsp_stall
// is high the response holds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_interval_set_table_defines.svh"
module sorted_interval_set_table #(
   parameter int NUM_SOURCES = sist_pkg::NUM_SOURCES_DEF,
   parameter int MAX_RANGES  = sist_pkg::MAX_RANGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sist_pkg::OP_W-1:0]      req_operation,
   input  logic [sist_pkg::SRC_W-1:0]     req_source,
   input  logic [sist_pkg::VAL_W-1:0]     req_range_begin,
   input  logic [sist_pkg::VAL_W-1:0]     req_range_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_status,
   output logic [sist_pkg::VAL_W-1:0]     rsp_number_count,
   output logic [sist_pkg::CNT_OUT_W-1:0] rsp_range_count
);
   import sist_pkg::*;

   // Command and status groups between the sequencer and the datapath.
   sist_cmd_type cmd;
   sist_sts_type sts;

   // The controller owns the handshake and the pass sequencing.
   sist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the range memories and the response register.
   sist_dp #(
      .NUM_SOURCES (NUM_SOURCES),
      .MAX_RANGES  (MAX_RANGES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_source       (req_source),
      .req_range_begin  (req_range_begin),
      .req_range_end    (req_range_end),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_number_count (rsp_number_count),
      .rsp_range_count  (rsp_range_count)
   );

   // A pending response keeps new requests out.
   `SIST_ASSERT_IMPLY(a_resp_blocks_req, clock, reset, rsp_valid, req_stall,
      "response without stall")
   // A response never appears in the cycle right after a request transfer.
   `SIST_ASSERT_NEXT(a_no_early_resp, clock, reset, req_valid && !req_stall,
      !rsp_valid, "early response")
   // The rewrite pass only completes when the result fits in the list.
   `SIST_ASSERT_IMPLY(a_fin_fits, clock, reset, cmd.fin, !sts.full, "list overflow written")
   // A full flag is only raised for a source holding the maximum list.
   `SIST_ASSERT_IMPLY(a_full_list, clock, reset, rsp_valid && rsp_status,
      rsp_range_count == CNT_OUT_W'(MAX_RANGES), "full flag with room left")

endmodule
`default_nettype wire
